// ===== hw/rtl/pfl_pkg.sv =====
// Shared types, codes and reset values for the playback fade light controller.
package pfl_pkg;

    localparam logic [3:0]  SHIFT_MAX = 4'd10;
    localparam logic [11:0] WIN_TOP   = 12'hfff;

    typedef enum logic [1:0] {
        MODE_SENSOR = 2'd0,
        MODE_ON     = 2'd1,
        MODE_OFF    = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        PS_INVALID = 3'd0,
        PS_STOPPED = 3'd1,
        PS_FADEOUT = 3'd2,
        PS_FADEIN  = 3'd3,
        PS_PLAYING = 3'd4
    } play_t;

    typedef enum logic [2:0] {
        OP_POWER      = 3'd0,
        OP_NEXT_DIR   = 3'd1,
        OP_NEXT_TRACK = 3'd2,
        OP_PREV_TRACK = 3'd3,
        OP_SAMPLE     = 3'd4,
        OP_TICK       = 3'd5,
        OP_START      = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        CMD_NONE       = 2'd0,
        CMD_NEXT_DIR   = 2'd1,
        CMD_NEXT_TRACK = 2'd2,
        CMD_PREV_TRACK = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_LUX_MODE     = 3'd0,
        REG_DARK_LEVEL   = 3'd1,
        REG_BRIGHT_LEVEL = 3'd2,
        REG_FADE_IN      = 3'd3,
        REG_FADE_OUT     = 3'd4,
        REG_INSTANT      = 3'd5,
        REG_USB_FOLLOW   = 3'd6,
        REG_SAVE_MODE    = 3'd7
    } reg_idx_t;

    localparam logic [1:0]  LUX_MODE_RST     = 2'd1;
    localparam logic [11:0] DARK_LEVEL_RST   = 12'd1000;
    localparam logic [11:0] BRIGHT_LEVEL_RST = 12'd2000;

    typedef struct packed {
        logic [1:0]  lux_mode;
        logic [11:0] dark_level;
        logic [11:0] bright_level;
        logic [7:0]  fade_in_period;
        logic [7:0]  fade_out_period;
        logic        snap_switch;
        logic        usb_follows_playback;
        logic        save_mode_enabled;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [11:0] sample;
        logic [1:0]  saved_mode;
    } item_t;

    typedef struct packed {
        logic        save_request;
        logic [1:0]  command;
        logic        sensor_running;
        logic [11:0] window_high;
        logic [11:0] window_low;
        logic [2:0]  play_state;
        logic [1:0]  mode_now;
        logic        muted;
        logic        usb_drive;
        logic        led_on;
        logic [3:0]  volume_shift;
    } res_t;

endpackage

// ===== hw/rtl/pfl_cfg.sv =====
// APB configuration register file for the playback fade light controller.
module pfl_cfg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output pfl_pkg::cfg_t    cfg
);

    pfl_pkg::cfg_t     cfg_reg;
    pfl_pkg::reg_idx_t idx;
    logic              wr_en;

    assign pready = 1'b1;
    assign idx    = pfl_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lux_mode             <= pfl_pkg::LUX_MODE_RST;
            cfg_reg.dark_level           <= pfl_pkg::DARK_LEVEL_RST;
            cfg_reg.bright_level         <= pfl_pkg::BRIGHT_LEVEL_RST;
            cfg_reg.fade_in_period       <= 8'd0;
            cfg_reg.fade_out_period      <= 8'd0;
            cfg_reg.snap_switch          <= 1'b0;
            cfg_reg.usb_follows_playback <= 1'b0;
            cfg_reg.save_mode_enabled    <= 1'b0;
        end else if (wr_en) begin
            case (idx)
                pfl_pkg::REG_LUX_MODE:     cfg_reg.lux_mode <= pwdata[1:0];
                pfl_pkg::REG_DARK_LEVEL:   cfg_reg.dark_level <= pwdata[11:0];
                pfl_pkg::REG_BRIGHT_LEVEL: cfg_reg.bright_level <= pwdata[11:0];
                pfl_pkg::REG_FADE_IN:      cfg_reg.fade_in_period <= pwdata[7:0];
                pfl_pkg::REG_FADE_OUT:     cfg_reg.fade_out_period <= pwdata[7:0];
                pfl_pkg::REG_INSTANT:      cfg_reg.snap_switch <= pwdata[0];
                pfl_pkg::REG_USB_FOLLOW:   cfg_reg.usb_follows_playback <= pwdata[0];
                pfl_pkg::REG_SAVE_MODE:    cfg_reg.save_mode_enabled <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = 32'd0;
        case (idx)
            pfl_pkg::REG_LUX_MODE:     prdata = {30'd0, cfg_reg.lux_mode};
            pfl_pkg::REG_DARK_LEVEL:   prdata = {20'd0, cfg_reg.dark_level};
            pfl_pkg::REG_BRIGHT_LEVEL: prdata = {20'd0, cfg_reg.bright_level};
            pfl_pkg::REG_FADE_IN:      prdata = {24'd0, cfg_reg.fade_in_period};
            pfl_pkg::REG_FADE_OUT:     prdata = {24'd0, cfg_reg.fade_out_period};
            pfl_pkg::REG_INSTANT:      prdata = {31'd0, cfg_reg.snap_switch};
            pfl_pkg::REG_USB_FOLLOW:   prdata = {31'd0, cfg_reg.usb_follows_playback};
            pfl_pkg::REG_SAVE_MODE:    prdata = {31'd0, cfg_reg.save_mode_enabled};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

// ===== hw/rtl/pfl_core.sv =====
// Controller state registers and the combinational event update.
module pfl_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  pfl_pkg::cfg_t  cfg,
    input  logic           step_en,
    input  pfl_pkg::item_t item,
    output pfl_pkg::res_t  result
);

    typedef struct packed {
        pfl_pkg::mode_t mode;
        pfl_pkg::play_t play;
        logic [3:0]     shift;
        logic [7:0]     tick;
        logic [7:0]     period;
        logic           fade_run;
        logic           mute;
        logic           led;
        logic           usb;
        logic           sensor;
        logic [11:0]    low;
        logic [11:0]    high;
    } st_t;

    st_t st_reg;
    st_t st_next;

    function automatic st_t set_play(input st_t s, input pfl_pkg::cfg_t c,
                                     input pfl_pkg::play_t target, input logic no_fade);
        st_t            r;
        pfl_pkg::play_t t;
        r = s;
        t = target;
        if (s.play != target) begin
            if (!no_fade) begin
                if (c.fade_out_period != 8'd0 && t == pfl_pkg::PS_STOPPED)
                    t = pfl_pkg::PS_FADEOUT;
                if (c.fade_in_period != 8'd0 && t == pfl_pkg::PS_PLAYING)
                    t = pfl_pkg::PS_FADEIN;
            end
            case (t)
                pfl_pkg::PS_STOPPED: begin
                    r.led = 1'b0;
                    if (c.usb_follows_playback)
                        r.usb = 1'b0;
                    r.mute  = 1'b1;
                    r.shift = pfl_pkg::SHIFT_MAX;
                end
                pfl_pkg::PS_FADEIN, pfl_pkg::PS_PLAYING: begin
                    r.led = 1'b1;
                    if (c.usb_follows_playback)
                        r.usb = 1'b1;
                    if (t == pfl_pkg::PS_FADEIN) begin
                        r.tick     = 8'd0;
                        r.period   = c.fade_in_period;
                        r.fade_run = 1'b1;
                    end else begin
                        r.shift = 4'd0;
                    end
                    if (s.play == pfl_pkg::PS_STOPPED)
                        r.mute = 1'b0;
                end
                pfl_pkg::PS_FADEOUT: begin
                    r.led      = 1'b0;
                    r.tick     = 8'd0;
                    r.period   = c.fade_out_period;
                    r.fade_run = 1'b1;
                end
                default: begin
                end
            endcase
            r.play = t;
        end
        return r;
    endfunction

    function automatic st_t update_window(input st_t s, input pfl_pkg::cfg_t c);
        st_t  r;
        logic to_dim;
        r = s;
        to_dim = (s.play >= pfl_pkg::PS_FADEIN && c.lux_mode == 2'd1) ||
                 (s.play <= pfl_pkg::PS_FADEOUT && c.lux_mode == 2'd2);
        if (to_dim) begin
            r.low  = 12'd0;
            r.high = c.bright_level;
        end else begin
            r.low  = c.dark_level;
            r.high = pfl_pkg::WIN_TOP;
        end
        return r;
    endfunction

    function automatic st_t set_mode(input st_t s, input pfl_pkg::cfg_t c,
                                     input pfl_pkg::mode_t m);
        st_t r;
        r = s;
        case (m)
            pfl_pkg::MODE_OFF: begin
                r.sensor = 1'b0;
                r = set_play(r, c, pfl_pkg::PS_STOPPED, c.snap_switch);
            end
            pfl_pkg::MODE_ON: begin
                r.sensor = 1'b0;
                r = set_play(r, c, pfl_pkg::PS_PLAYING, c.snap_switch);
            end
            default: begin
                if (r.play == pfl_pkg::PS_INVALID)
                    r = set_play(r, c, pfl_pkg::PS_STOPPED, 1'b1);
                r = update_window(r, c);
                r.sensor = 1'b1;
            end
        endcase
        r.mode = m;
        return r;
    endfunction

    function automatic st_t fade_step(input st_t s, input pfl_pkg::cfg_t c);
        st_t r;
        r = s;
        if (s.play == pfl_pkg::PS_FADEIN) begin
            if (s.shift != 4'd0) begin
                r.shift = s.shift - 4'd1;
            end else begin
                r.fade_run = 1'b0;
                r = set_play(r, c, pfl_pkg::PS_PLAYING, 1'b1);
            end
        end else if (s.play == pfl_pkg::PS_FADEOUT) begin
            if (s.shift < pfl_pkg::SHIFT_MAX) begin
                r.shift = s.shift + 4'd1;
            end else begin
                r.fade_run = 1'b0;
                r = set_play(r, c, pfl_pkg::PS_STOPPED, 1'b1);
            end
        end
        return r;
    endfunction

    pfl_pkg::op_t   op;
    st_t            s;
    pfl_pkg::mode_t m;
    logic [1:0]     cmd;
    logic           save;

    assign op = pfl_pkg::op_t'(item.op);

    always_comb begin
        s    = st_reg;
        m    = pfl_pkg::MODE_SENSOR;
        cmd  = pfl_pkg::CMD_NONE;
        save = 1'b0;
        case (op)
            pfl_pkg::OP_POWER: begin
                case (st_reg.mode)
                    pfl_pkg::MODE_SENSOR: m = pfl_pkg::MODE_ON;
                    pfl_pkg::MODE_ON:     m = pfl_pkg::MODE_OFF;
                    pfl_pkg::MODE_OFF:    m = pfl_pkg::MODE_SENSOR;
                    default:              m = pfl_pkg::MODE_ON;
                endcase
                if (m == pfl_pkg::MODE_SENSOR && cfg.lux_mode == 2'd0)
                    m = pfl_pkg::MODE_ON;
                s    = set_mode(s, cfg, m);
                save = cfg.save_mode_enabled;
            end
            pfl_pkg::OP_NEXT_DIR, pfl_pkg::OP_NEXT_TRACK, pfl_pkg::OP_PREV_TRACK: begin
                cmd = item.op[1:0];
            end
            pfl_pkg::OP_SAMPLE: begin
                if (st_reg.sensor && st_reg.mode == pfl_pkg::MODE_SENSOR) begin
                    if (item.sample < cfg.dark_level)
                        s = set_play(s, cfg, (cfg.lux_mode == 2'd1) ?
                                     pfl_pkg::PS_PLAYING : pfl_pkg::PS_STOPPED, 1'b0);
                    else if (item.sample > cfg.bright_level)
                        s = set_play(s, cfg, (cfg.lux_mode == 2'd1) ?
                                     pfl_pkg::PS_STOPPED : pfl_pkg::PS_PLAYING, 1'b0);
                    s = update_window(s, cfg);
                end
            end
            pfl_pkg::OP_TICK: begin
                if (st_reg.fade_run) begin
                    if (st_reg.tick >= st_reg.period) begin
                        s.tick = 8'd0;
                        s = fade_step(s, cfg);
                    end else begin
                        s.tick = st_reg.tick + 8'd1;
                    end
                end
            end
            pfl_pkg::OP_START: begin
                s.mute = 1'b0;
                s.play = pfl_pkg::PS_INVALID;
                if (cfg.save_mode_enabled)
                    m = (item.saved_mode > 2'd2) ? pfl_pkg::MODE_OFF :
                        pfl_pkg::mode_t'(item.saved_mode);
                else
                    m = (cfg.lux_mode != 2'd0) ? pfl_pkg::MODE_SENSOR :
                        pfl_pkg::MODE_OFF;
                s = set_mode(s, cfg, m);
            end
            default: begin
            end
        endcase
        st_next = step_en ? s : st_reg;

        result.volume_shift   = s.shift;
        result.led_on         = s.led;
        result.usb_drive      = s.usb;
        result.muted          = s.mute;
        result.mode_now       = s.mode;
        result.play_state     = s.play;
        result.window_low     = s.low;
        result.window_high    = s.high;
        result.sensor_running = s.sensor;
        result.command        = cmd;
        result.save_request   = save;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.mode     <= pfl_pkg::MODE_SENSOR;
            st_reg.play     <= pfl_pkg::PS_STOPPED;
            st_reg.shift    <= 4'd0;
            st_reg.tick     <= 8'd0;
            st_reg.period   <= 8'd0;
            st_reg.fade_run <= 1'b0;
            st_reg.mute     <= 1'b0;
            st_reg.led      <= 1'b0;
            st_reg.usb      <= 1'b0;
            st_reg.sensor   <= 1'b0;
            st_reg.low      <= 12'd0;
            st_reg.high     <= pfl_pkg::WIN_TOP;
        end else begin
            st_reg <= st_next;
        end
    end

    // The shift only ever moves between full volume and the quietest step.
    a_shift_range: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.shift <= pfl_pkg::SHIFT_MAX)
        else $error("volume shift beyond its range");

    // Entering either fade always arms the timer, and only the fade end clears it.
    a_fade_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.play == pfl_pkg::PS_FADEIN || st_reg.play == pfl_pkg::PS_FADEOUT)
        |-> st_reg.fade_run)
        else $error("fading without a running fade timer");

    a_led_play: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.led == (st_reg.play == pfl_pkg::PS_FADEIN ||
                       st_reg.play == pfl_pkg::PS_PLAYING))
        else $error("LED does not match playback state");

    // An event that is not stepped leaves the controller state alone.
    a_hold_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !step_en |=> $stable(st_reg))
        else $error("state changed without an event");

endmodule

// ===== hw/rtl/playback_fade_light_controller.sv =====
// Top level: stream input register, controller core, result register and APB port.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------
//  s_       | in        | s_tvalid/s_tready  | tuser: op; tdata: sample, saved_mode
//  m_       | out       | m_tvalid/m_tready  | tdata: 40-bit result, one per event
//  apb      | in        | psel/penable       | eight configuration registers
//
// Each event is held in the input register and is applied to the
// controller state as it moves into the result register, which drives
// m_tdata; one event per cycle is sustained while m_tready stays high.
// While a result waits on m_tready, the input register can still take one
// transfer; with both registers full, s_tready drops. Reset is synchronous
// on aresetn and returns the controller to sensor mode, stopped.
module playback_fade_light_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] sample, [13:12] saved_mode, [15:14] zero
    input  logic [2:0]  s_tuser,   // [2:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] volume_shift, [4] led_on, [5] usb_drive, [6] muted,
    // [8:7] mode_now, [11:9] play_state, [23:12] window_low,
    // [35:24] window_high, [36] sensor_running, [38:37] command,
    // [39] save_request
    output logic [39:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    pfl_pkg::cfg_t  cfg;
    pfl_pkg::item_t in_item_reg;
    pfl_pkg::res_t  core_res;
    pfl_pkg::res_t  out_res_reg;
    logic           in_valid_reg;
    logic           out_valid_reg;
    logic           advance;
    logic           s_xfer;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg;

    pfl_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pfl_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step_en (advance),
        .item    (in_item_reg),
        .result  (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_xfer)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_item_reg.op         <= s_tuser;
            in_item_reg.sample     <= s_tdata[11:0];
            in_item_reg.saved_mode <= s_tdata[13:12];
        end
        if (advance)
            out_res_reg <= core_res;
    end

    // A waiting event must not be dropped while the result register is blocked.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_tready |=> in_valid_reg && $stable(in_item_reg))
        else $error("input event lost while the output is stalled");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_res_reg))
        else $error("stalled result overwritten");

    a_no_accept_full: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_tready |-> !s_tready)
        else $error("input taken with both registers full");

endmodule
